/* hdl/vn2d_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vn2d_pkg
// Shared constants, types and the blend function of the 2D value noise core.
// ----------------------------------------------------------------------------
package vn2d_pkg;

    // Configuration register indexes
    localparam logic REG_HASH_SEED     = 1'b0;
    localparam logic REG_INVERSE_SCALE = 1'b1;

    // Register reset values
    localparam logic [31:0] HASH_SEED_RESET = 32'h0000_0000;
    localparam logic [23:0] INV_SCALE_RESET = 24'h01_0000;

    // Hash mixer multipliers
    localparam logic [31:0] HASH_MUL_X = 32'h9E37_79B9;
    localparam logic [31:0] HASH_MUL_Z = 32'h85EB_CA6B;
    localparam logic [31:0] MIX_MUL_A  = 32'h7FEB_352D;
    localparam logic [31:0] MIX_MUL_B  = 32'h846C_A68B;

    // 3 * 2^16 for the smoothstep term
    localparam logic [17:0] SMOOTH_THREE = 18'h3_0000;

    // Rounding constant for the Q0.16 weight (2^31)
    localparam logic [50:0] WEIGHT_ROUND = 51'h0_8000_0000;

    // Per-stage advance strobes of one hash lane
    typedef struct packed {
        logic s3;
        logic s4;
        logic s5;
        logic s6;
    } lane_adv_t;

    // lerp(a, b, w) = (a*(65536 - w) + b*w + 32768) >> 16, written as
    // (a*65536 + (b - a)*w + 32768) >> 16 so it needs one multiplier.
    function automatic logic [23:0] blend(
        input logic [23:0] a,
        input logic [23:0] b,
        input logic [16:0] w
    );
        logic signed [24:0] diff;
        logic signed [17:0] ws;
        logic signed [42:0] prod;
        logic signed [42:0] acc;
        diff = $signed({1'b0, b}) - $signed({1'b0, a});
        ws   = $signed({1'b0, w});
        prod = diff * ws;
        acc  = $signed({3'b000, a, 16'h0000}) + prod + 43'sd32768;
        if (acc[40])
        begin
            blend = 24'hFF_FFFF;
        end
        else
        begin
            blend = acc[39:16];
        end
    endfunction

endpackage

/* hdl/vn2d_mix_lane.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vn2d_mix_lane
// Four-stage finalizer of one lattice corner hash; yields the top 24 bits.
// ----------------------------------------------------------------------------
module vn2d_mix_lane
(
    input  logic                clk,
    input  vn2d_pkg::lane_adv_t adv,
    input  logic [31:0]         h_in,
    output logic [23:0]         value
);

    logic [31:0] h3_reg, h3_next;
    logic [31:0] h4_reg, h4_next;
    logic [31:0] h5_reg, h5_next;
    logic [23:0] v6_reg, v6_next;
    logic [31:0] t5;

    // Fold, multiply, fold and multiply, final fold
    always_comb
    begin
        h3_next = h_in ^ (h_in >> 16);
        h4_next = h3_reg * vn2d_pkg::MIX_MUL_A;
        t5      = h4_reg ^ (h4_reg >> 15);
        h5_next = t5 * vn2d_pkg::MIX_MUL_B;
        // (h ^ (h >> 16)) >> 8 is (h >> 8) ^ (h >> 24)
        v6_next = h5_reg[31:8] ^ {16'h0000, h5_reg[31:24]};
    end

    always_ff @(posedge clk)
    begin
        if (adv.s3)
        begin
            h3_reg <= h3_next;
        end
        if (adv.s4)
        begin
            h4_reg <= h4_next;
        end
        if (adv.s5)
        begin
            h5_reg <= h5_next;
        end
        if (adv.s6)
        begin
            v6_reg <= v6_next;
        end
    end

    assign value = v6_reg;

endmodule

/* hdl/value_noise_2d_core.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// value_noise_2d_core
// Seeded 2D value noise: scales a Q15.8 position to the lattice, hashes the
// four corners and returns the smoothstep bilinear blend as Q0.24.
// ----------------------------------------------------------------------------
//  channel   | dir | signals                           | beat contents
//  ----------+-----+-----------------------------------+------------------------
//  s_axis    | in  | s_axis_tvalid/tready/tdata[47:0]  | x_pos, z_pos
//  m_axis    | out | m_axis_tvalid/tready/tdata[23:0]  | potential
//  cfg       | in  | cfg_we, cfg_index, cfg_data[31:0] | hash_seed, inverse_scale
//
//  One beat per cycle sustained while m_axis_tready stays high; the stage
//  chain is scale multiply, corner multiply, weight/hash fold, two hash
//  multiplies, hash fold, x blend, z blend.
//  rst_n clears all stage valid bits and loads the register defaults.
//  Each stage holds only while it is full and the one after it cannot take
//  data, so bubbles are squeezed out and stalls lose or repeat nothing.
// ----------------------------------------------------------------------------
module value_noise_2d_core
(
    input  logic        clk,
    input  logic        rst_n,
    // cfg
    input  logic        cfg_we,
    input  logic        cfg_index,
    input  logic [31:0] cfg_data,
    // input stream
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [47:0] s_axis_tdata,   // [23:0] x_pos, [47:24] z_pos
    // output stream
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [23:0] m_axis_tdata    // [23:0] potential
);

    // Configuration registers
    logic [31:0] hash_seed_reg;
    logic [23:0] inv_scale_reg;

    // Stage control
    logic [8:1] vld_reg, vld_next;
    logic [8:1] en;

    // Stage 1: scaled positions
    logic signed [47:0] px1_reg, px1_next;
    logic signed [47:0] pz1_reg, pz1_next;
    logic signed [23:0] x_pos;
    logic signed [23:0] z_pos;

    // Stage 2: corner products and weight terms
    logic [31:0] mx2_reg, mx2_next;
    logic [31:0] mz2_reg, mz2_next;
    logic [31:0] f2x2_reg, f2x2_next;
    logic [31:0] f2z2_reg, f2z2_next;
    logic [17:0] sx2_reg, sx2_next;
    logic [17:0] sz2_reg, sz2_next;
    logic [31:0] cx, cz;
    logic [15:0] fx, fz;

    // Stage 3..7: weights
    logic [16:0] wx3_reg, wx3_next;
    logic [16:0] wz3_reg, wz3_next;
    logic [16:0] wx4_reg, wz4_reg;
    logic [16:0] wx5_reg, wz5_reg;
    logic [16:0] wx6_reg, wz6_reg;
    logic [16:0] wz7_reg;
    logic [49:0] wpx, wpz;
    logic [50:0] wsx, wsz;

    // Corner hashes
    logic [31:0] mx_p1, mz_p1;
    logic [31:0] h00, h10, h01, h11;
    logic [23:0] v00, v10, v01, v11;
    vn2d_pkg::lane_adv_t lane_adv;

    // Stage 7 and 8: blends
    logic [23:0] bot7_reg, bot7_next;
    logic [23:0] top7_reg, top7_next;
    logic [23:0] pot8_reg, pot8_next;

    // Configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hash_seed_reg <= vn2d_pkg::HASH_SEED_RESET;
            inv_scale_reg <= vn2d_pkg::INV_SCALE_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                vn2d_pkg::REG_HASH_SEED:     hash_seed_reg <= cfg_data;
                vn2d_pkg::REG_INVERSE_SCALE: inv_scale_reg <= cfg_data[23:0];
                default:                     ;
            endcase
        end
    end

    // Stage enables: a stage loads when empty or when its successor loads
    always_comb
    begin
        en[8] = !vld_reg[8] || m_axis_tready;
        for (int i = 7; i >= 1; i--)
        begin
            en[i] = !vld_reg[i] || en[i + 1];
        end
        vld_next = vld_reg;
        if (en[1])
        begin
            vld_next[1] = s_axis_tvalid;
        end
        for (int i = 2; i <= 8; i++)
        begin
            if (en[i])
            begin
                vld_next[i] = vld_reg[i - 1];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            vld_reg <= vld_next;
        end
    end

    assign s_axis_tready = en[1];

    // Stage 1: position times inverse scale (Q15.8 * Q8.16 -> Q.24)
    assign x_pos    = $signed(s_axis_tdata[23:0]);
    assign z_pos    = $signed(s_axis_tdata[47:24]);
    assign px1_next = x_pos * $signed({1'b0, inv_scale_reg});
    assign pz1_next = z_pos * $signed({1'b0, inv_scale_reg});

    // Stage 2: cell times hash multiplier, fraction squared, 3 - 2f
    always_comb
    begin
        cx        = {{8{px1_reg[47]}}, px1_reg[47:24]};
        cz        = {{8{pz1_reg[47]}}, pz1_reg[47:24]};
        fx        = px1_reg[23:8];
        fz        = pz1_reg[23:8];
        mx2_next  = cx * vn2d_pkg::HASH_MUL_X;
        mz2_next  = cz * vn2d_pkg::HASH_MUL_Z;
        f2x2_next = fx * fx;
        f2z2_next = fz * fz;
        sx2_next  = vn2d_pkg::SMOOTH_THREE - {1'b0, fx, 1'b0};
        sz2_next  = vn2d_pkg::SMOOTH_THREE - {1'b0, fz, 1'b0};
    end

    // Stage 3: smoothstep weights; corner seeds go into the hash lanes
    always_comb
    begin
        wpx      = f2x2_reg * sx2_reg;
        wpz      = f2z2_reg * sz2_reg;
        wsx      = {1'b0, wpx} + vn2d_pkg::WEIGHT_ROUND;
        wsz      = {1'b0, wpz} + vn2d_pkg::WEIGHT_ROUND;
        wx3_next = wsx[48:32];
        wz3_next = wsz[48:32];
        // (c + 1) * K is c * K + K
        mx_p1    = mx2_reg + vn2d_pkg::HASH_MUL_X;
        mz_p1    = mz2_reg + vn2d_pkg::HASH_MUL_Z;
        h00      = hash_seed_reg ^ mx2_reg ^ mz2_reg;
        h10      = hash_seed_reg ^ mx_p1   ^ mz2_reg;
        h01      = hash_seed_reg ^ mx2_reg ^ mz_p1;
        h11      = hash_seed_reg ^ mx_p1   ^ mz_p1;
    end

    assign lane_adv.s3 = en[3];
    assign lane_adv.s4 = en[4];
    assign lane_adv.s5 = en[5];
    assign lane_adv.s6 = en[6];

    // Stages 3..6: one mixer lane per corner
    vn2d_mix_lane u_lane00 (.clk(clk), .adv(lane_adv), .h_in(h00), .value(v00));
    vn2d_mix_lane u_lane10 (.clk(clk), .adv(lane_adv), .h_in(h10), .value(v10));
    vn2d_mix_lane u_lane01 (.clk(clk), .adv(lane_adv), .h_in(h01), .value(v01));
    vn2d_mix_lane u_lane11 (.clk(clk), .adv(lane_adv), .h_in(h11), .value(v11));

    // Stage 7: blend along x; stage 8: blend along z
    assign bot7_next = vn2d_pkg::blend(v00, v10, wx6_reg);
    assign top7_next = vn2d_pkg::blend(v01, v11, wx6_reg);
    assign pot8_next = vn2d_pkg::blend(bot7_reg, top7_reg, wz7_reg);

    // Stage data registers
    always_ff @(posedge clk)
    begin
        if (en[1])
        begin
            px1_reg <= px1_next;
            pz1_reg <= pz1_next;
        end
        if (en[2])
        begin
            mx2_reg  <= mx2_next;
            mz2_reg  <= mz2_next;
            f2x2_reg <= f2x2_next;
            f2z2_reg <= f2z2_next;
            sx2_reg  <= sx2_next;
            sz2_reg  <= sz2_next;
        end
        if (en[3])
        begin
            wx3_reg <= wx3_next;
            wz3_reg <= wz3_next;
        end
        if (en[4])
        begin
            wx4_reg <= wx3_reg;
            wz4_reg <= wz3_reg;
        end
        if (en[5])
        begin
            wx5_reg <= wx4_reg;
            wz5_reg <= wz4_reg;
        end
        if (en[6])
        begin
            wx6_reg <= wx5_reg;
            wz6_reg <= wz5_reg;
        end
        if (en[7])
        begin
            bot7_reg <= bot7_next;
            top7_reg <= top7_next;
            wz7_reg  <= wz6_reg;
        end
        if (en[8])
        begin
            pot8_reg <= pot8_next;
        end
    end

    assign m_axis_tvalid = vld_reg[8];
    assign m_axis_tdata  = pot8_reg;

    // Input only blocks when every stage is full and the output is stalled
    a_full_when_blocked: assert property (@(posedge clk) disable iff (!rst_n)
        !s_axis_tready |-> (&vld_reg) && !m_axis_tready)
        else $error("input blocked while pipeline has room");

    // Smoothstep weight never exceeds one in Q0.16
    a_weight_range: assert property (@(posedge clk) disable iff (!rst_n)
        vld_reg[3] |-> (wx3_reg <= 17'h1_0000) && (wz3_reg <= 17'h1_0000))
        else $error("weight out of range");

    // A full stage behind a stalled output keeps its beat
    a_no_loss: assert property (@(posedge clk) disable iff (!rst_n)
        vld_reg[8] && !m_axis_tready && vld_reg[7] |=> vld_reg[7] && vld_reg[8])
        else $error("beat dropped under stall");

endmodule
